// ----- src/lp4_pkg.sv -----
// shared constants and types for the four-pole ladder low-pass filter
`default_nettype none
package lp4_pkg;

	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF    = 20;

	localparam int POLE_W     = 22;
	localparam int HALF_W     = 21;
	localparam int RES_W      = 23;
	localparam int COEF_OPW   = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	localparam logic [HALF_W-1:0] HALF_RESET = 21'd524288;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE = 2'd0,
		REG_HALF = 2'd1,
		REG_RES  = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_FB_GO,
		C_FB_WT,
		C_SUM,
		C_M1_GO,
		C_M1_WT,
		C_M2_GO,
		C_M2_WT,
		C_SQ_GO,
		C_SQ_WT,
		C_CU_GO,
		C_CU_WT,
		C_D_GO,
		C_D_WT,
		C_OUT
	} core_state_t;

endpackage
`default_nettype wire

// ----- src/lp4_mul.sv -----
// bit-serial signed multiplier with rounding shift and saturation
`default_nettype none
module lp4_mul #(
	parameter int MW        = 25,
	parameter int SW        = 24,
	parameter int FRAC_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [MW-1:0]        a,
	input  wire logic [MW-1:0]        b,
	output logic                      done,
	output logic [SW-1:0]             product
);
	import lp4_pkg::*;

	localparam int PW = 2 * MW;
	localparam int CW = $clog2(MW);
	localparam logic signed [PW-1:0] SMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [PW-1:0] SMIN = ~SMAX;
	localparam logic signed [PW-1:0] RND  =
		{{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

	logic                 run_q;
	logic                 fin_q;
	logic                 done_q;
	logic [CW-1:0]        cnt_q;
	logic signed [MW-1:0] a_q;
	logic [MW-1:0]        b_q;
	logic signed [MW-1:0] hi_q;
	logic [MW-1:0]        lo_q;
	logic [SW-1:0]        res_q;

	logic                 last;
	logic signed [MW:0]   hi_ext;
	logic signed [MW:0]   a_ext;
	logic signed [MW:0]   sum;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] rnd;
	logic signed [PW-1:0] shf;
	logic [SW-1:0]        sat_res;

	assign last   = (cnt_q == CW'(MW - 1));
	assign hi_ext = {hi_q[MW-1], hi_q};
	assign a_ext  = {a_q[MW-1], a_q};

	// sign bit of the multiplier carries negative weight
	always_comb begin
		if (b_q[0]) begin
			sum = last ? (hi_ext - a_ext) : (hi_ext + a_ext);
		end else begin
			sum = hi_ext;
		end
	end

	assign prod = {hi_q, lo_q};
	assign rnd  = prod + RND;
	assign shf  = rnd >>> FRAC_BITS;

	always_comb begin
		priority if (shf > SMAX) begin
			sat_res = SMAX[SW-1:0];
		end else if (shf < SMIN) begin
			sat_res = SMIN[SW-1:0];
		end else begin
			sat_res = shf[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			if (start) begin
				run_q <= 1'b1;
				fin_q <= 1'b0;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (last) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else begin
				fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= '0;
			lo_q <= '0;
		end else if (run_q) begin
			hi_q <= sum[MW:1];
			lo_q <= {sum[0], lo_q[MW-1:1]};
			b_q  <= {1'b0, b_q[MW-1:1]};
		end
		if (fin_q) begin
			res_q <= sat_res;
		end
	end

	assign done    = done_q;
	assign product = res_q;

endmodule
`default_nettype wire

// ----- src/lp4_core.sv -----
// sequencer and state registers for the four ladder stages and the clipper
`default_nettype none
module lp4_core #(
	parameter int MW        = 25,
	parameter int SW        = 24,
	parameter int FRAC_BITS = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [SW-1:0]               sample,
	input  wire logic [lp4_pkg::POLE_W-1:0]  pole,
	input  wire logic [lp4_pkg::HALF_W-1:0]  half,
	input  wire logic [lp4_pkg::RES_W-1:0]   res,
	output logic                             idle,
	output logic                             res_valid,
	input  wire logic                        res_take,
	output logic [SW-1:0]                    result
);
	import lp4_pkg::*;

	localparam logic [MW-1:0] RECIP_SIX = MW'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6);

	core_state_t   state_q;
	core_state_t   state_nx;
	logic [1:0]    idx_q;
	logic [SW-1:0] rs_q [4];
	logic [SW-1:0] up_q [4];
	logic [SW-1:0] in_q;
	logic [SW-1:0] u_q;
	logic [SW-1:0] sum_q;
	logic [SW-1:0] t_q;
	logic [SW-1:0] y_q;
	logic [SW-1:0] res_q;

	logic          mul_start;
	logic [MW-1:0] mul_a;
	logic [MW-1:0] mul_b;
	logic          mul_done;
	logic [SW-1:0] mul_res;

	logic [SW-1:0] add_a;
	logic [SW-1:0] add_b;
	logic          add_sub;
	logic [SW:0]   add_raw;
	logic [SW-1:0] add_res;
	logic [SW-1:0] clip;

	function automatic logic [MW-1:0] sx(input logic [SW-1:0] v);
		return {{(MW-SW){v[SW-1]}}, v};
	endfunction

	lp4_mul #(
		.MW       (MW),
		.SW       (SW),
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.product(mul_res)
	);

	// saturating add and subtract
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			C_FB_WT: begin
				add_a   = in_q;
				add_b   = mul_res;
				add_sub = 1'b1;
			end
			C_SUM: begin
				add_a = u_q;
				add_b = up_q[0];
			end
			C_M2_WT: begin
				add_a   = t_q;
				add_b   = mul_res;
				add_sub = 1'b1;
			end
			C_D_WT: begin
				add_a   = y_q;
				add_b   = mul_res;
				add_sub = 1'b1;
			end
			default: begin
				add_a = '0;
			end
		endcase
	end

	assign add_raw = add_sub ? ({add_a[SW-1], add_a} - {add_b[SW-1], add_b})
	                         : ({add_a[SW-1], add_a} + {add_b[SW-1], add_b});

	always_comb begin
		if (add_raw[SW] != add_raw[SW-1]) begin
			add_res = add_raw[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			add_res = add_raw[SW-1:0];
		end
	end

	// sign flip in the clipper forces zero
	assign clip = (y_q[SW-1] != add_res[SW-1]) ? '0 : add_res;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			C_FB_GO: begin
				mul_a = {{(MW-RES_W){1'b0}}, res};
				mul_b = sx(rs_q[3]);
			end
			C_M1_GO: begin
				mul_a = sx(sum_q);
				mul_b = {{(MW-HALF_W){1'b0}}, half};
			end
			C_M2_GO: begin
				mul_a = {{(MW-POLE_W){pole[POLE_W-1]}}, pole};
				mul_b = sx(rs_q[0]);
			end
			C_SQ_GO: begin
				mul_a = sx(y_q);
				mul_b = sx(y_q);
			end
			C_CU_GO: begin
				mul_a = sx(t_q);
				mul_b = sx(y_q);
			end
			C_D_GO: begin
				mul_a = sx(t_q);
				mul_b = RECIP_SIX;
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		mul_start = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				if (start) state_nx = C_FB_GO;
			end
			C_FB_GO: begin
				mul_start = 1'b1;
				state_nx  = C_FB_WT;
			end
			C_FB_WT: begin
				if (mul_done) state_nx = C_SUM;
			end
			C_SUM: begin
				state_nx = C_M1_GO;
			end
			C_M1_GO: begin
				mul_start = 1'b1;
				state_nx  = C_M1_WT;
			end
			C_M1_WT: begin
				if (mul_done) state_nx = C_M2_GO;
			end
			C_M2_GO: begin
				mul_start = 1'b1;
				state_nx  = C_M2_WT;
			end
			C_M2_WT: begin
				if (mul_done) state_nx = (idx_q == 2'd3) ? C_SQ_GO : C_SUM;
			end
			C_SQ_GO: begin
				mul_start = 1'b1;
				state_nx  = C_SQ_WT;
			end
			C_SQ_WT: begin
				if (mul_done) state_nx = C_CU_GO;
			end
			C_CU_GO: begin
				mul_start = 1'b1;
				state_nx  = C_CU_WT;
			end
			C_CU_WT: begin
				if (mul_done) state_nx = C_D_GO;
			end
			C_D_GO: begin
				mul_start = 1'b1;
				state_nx  = C_D_WT;
			end
			C_D_WT: begin
				if (mul_done) state_nx = C_OUT;
			end
			C_OUT: begin
				if (res_take) state_nx = C_IDLE;
			end
			default: begin
				state_nx = C_IDLE;
			end
		endcase
	end

	// filter state, rotated once per stage so the current stage sits at the head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int i = 0; i < 4; i++) begin
				rs_q[i] <= '0;
				up_q[i] <= '0;
			end
		end else begin
			if (state_q == C_FB_WT && mul_done) begin
				idx_q <= '0;
			end
			if (state_q == C_M2_WT && mul_done) begin
				idx_q <= idx_q + 2'd1;
				for (int i = 0; i < 3; i++) begin
					rs_q[i] <= rs_q[i+1];
					up_q[i] <= up_q[i+1];
				end
				rs_q[3] <= add_res;
				up_q[3] <= u_q;
			end
			if (state_q == C_D_WT && mul_done) begin
				rs_q[3] <= clip;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			in_q <= sample;
		end
		if (state_q == C_FB_WT && mul_done) begin
			u_q <= add_res;
		end
		if (state_q == C_SUM) begin
			sum_q <= add_res;
		end
		if ((state_q == C_M1_WT || state_q == C_SQ_WT || state_q == C_CU_WT) && mul_done) begin
			t_q <= mul_res;
		end
		if (state_q == C_M2_WT && mul_done) begin
			y_q <= add_res;
			u_q <= add_res;
		end
		if (state_q == C_D_WT && mul_done) begin
			res_q <= clip;
		end
	end

	assign idle      = (state_q == C_IDLE);
	assign res_valid = (state_q == C_OUT);
	assign result    = res_q;

endmodule
`default_nettype wire

// ----- src/ladder_lowpass_4pole.sv -----
// four-pole resonant ladder low-pass filter with cubic soft clipper
// each result is computed by twelve passes through one bit-serial multiplier,
// whose operand width is MW = max(width, 24, frac)+1
// a new item is accepted only after the core hands its result to the output register, held while it stalls
// reset: asynchronous, clears the filter state to zero, coefficients to pole 0, half gain 0.5,
// resonance 0, and empties the output register
`default_nettype none
module ladder_lowpass_4pole #(
	parameter int SAMPLE_WIDTH = lp4_pkg::SAMPLE_WIDTH_DEF,
	parameter int FRAC_BITS    = lp4_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	input  wire logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,  // sample_in
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          m_axis_tdata,  // sample_out
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [lp4_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [lp4_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import lp4_pkg::*;

	localparam int DW  = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int MW0 = (SAMPLE_WIDTH > COEF_OPW) ? SAMPLE_WIDTH : COEF_OPW;
	localparam int MW  = ((MW0 > FRAC_BITS) ? MW0 : FRAC_BITS) + 1;

	logic [POLE_W-1:0]       pole_q;
	logic [HALF_W-1:0]       half_q;
	logic [RES_W-1:0]        res_q;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_q;

	logic                    core_idle;
	logic                    core_valid;
	logic                    core_take;
	logic [SAMPLE_WIDTH-1:0] core_result;
	logic                    in_acc;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = core_idle;
	assign in_acc        = s_axis_tvalid & core_idle;
	assign core_take     = core_valid & (~out_valid_q | m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q <= '0;
			half_q <= HALF_RESET;
			res_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POLE: pole_q <= cfg_data[POLE_W-1:0];
				REG_HALF: half_q <= cfg_data[HALF_W-1:0];
				REG_RES:  res_q  <= cfg_data[RES_W-1:0];
				default: begin
					pole_q <= pole_q;
				end
			endcase
		end
	end

	lp4_core #(
		.MW       (MW),
		.SW       (SAMPLE_WIDTH),
		.FRAC_BITS(FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_acc),
		.sample   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.pole     (pole_q),
		.half     (half_q),
		.res      (res_q),
		.idle     (core_idle),
		.res_valid(core_valid),
		.res_take (core_take),
		.result   (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_take) begin
			out_q <= core_result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DW'(out_q);

endmodule
`default_nettype wire

// ----- dv/ladder_checker.sv -----
// checker for the ladder low-pass filter: predicts every output sample and compares it
module ladder_checker #(
	parameter int SW = lp4_pkg::SAMPLE_WIDTH_DEF,
	parameter int FB = lp4_pkg::FRAC_BITS_DEF,
	parameter int DW = ((SW + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [DW-1:0]                  s_axis_tdata,  // sample_in
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [DW-1:0]                  m_axis_tdata,  // sample_out
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [lp4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lp4_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             outstanding,
	output int                             checked,
	output int                             flips
);
	import lp4_pkg::*;

	localparam longint S_HI     = (longint'(1) << (SW - 1)) - 1;
	localparam longint S_LO     = -(longint'(1) << (SW - 1));
	localparam longint HALF_LSB = longint'(1) << (FB - 1);
	localparam longint SIXTH    = ((longint'(1) << FB) + 3) / 6;

	logic signed [POLE_W-1:0] pole_c;
	logic        [HALF_W-1:0] half_c;
	logic        [RES_W-1:0]  res_c;

	logic signed [SW-1:0] feed_prev;
	logic signed [SW-1:0] stg [4];
	logic signed [SW-1:0] stg_prev [3];

	logic signed [SW-1:0] expected_samples [$];
	logic signed [SW-1:0] want_s;
	logic signed [SW-1:0] got_s;

	function automatic longint clamp(input longint v);
		if (v > S_HI) return S_HI;
		if (v < S_LO) return S_LO;
		return v;
	endfunction

	// exact product, round half up, saturate
	function automatic longint mulq(input longint a, input longint b);
		return clamp((a * b + HALF_LSB) >>> FB);
	endfunction

	function automatic longint pole_step(input longint u, input longint u_prev, input longint y);
		longint sum;
		sum = clamp(u + u_prev);
		return clamp(mulq(sum, half_c) - mulq(pole_c, y));
	endfunction

	task automatic predict_sample(input logic signed [SW-1:0] smp,
			output logic signed [SW-1:0] out_s);
		longint x;
		longint y;
		longint sq;
		longint cu;
		longint c;
		x = clamp(smp - mulq(res_c, stg[3]));
		stg[0] = SW'(pole_step(x, feed_prev, stg[0]));
		stg[1] = SW'(pole_step(stg[0], stg_prev[0], stg[1]));
		stg[2] = SW'(pole_step(stg[1], stg_prev[1], stg[2]));
		y = pole_step(stg[2], stg_prev[2], stg[3]);
		sq = mulq(y, y);
		cu = mulq(sq, y);
		c = clamp(y - mulq(cu, SIXTH));
		// clipper must not change the sign of the stage output
		if ((y < 0) != (c < 0)) begin
			c = 0;
			flips++;
		end
		stg[3] = SW'(c);
		feed_prev = SW'(x);
		for (int i = 0; i < 3; i++) stg_prev[i] = stg[i];
		out_s = SW'(c);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on result %0d: %s, got %0d expected %0d", checked, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_c = '0;
			half_c = HALF_RESET;
			res_c = '0;
			feed_prev = '0;
			for (int i = 0; i < 4; i++) stg[i] = '0;
			for (int i = 0; i < 3; i++) stg_prev[i] = '0;
			expected_samples.delete();
			mismatches = 0;
			checked = 0;
			flips = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_POLE: pole_c = cfg_data[POLE_W-1:0];
					REG_HALF: half_c = cfg_data[HALF_W-1:0];
					REG_RES:  res_c = cfg_data[RES_W-1:0];
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_s = m_axis_tdata[SW-1:0];
				if (expected_samples.size() == 0) begin
					report_mismatch("sample_out with no item pending", got_s, 0);
				end else begin
					want_s = expected_samples.pop_front();
					if (got_s != want_s) report_mismatch("sample_out", got_s, want_s);
					checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_sample(s_axis_tdata[SW-1:0], want_s);
				expected_samples.push_back(want_s);
			end
			outstanding <= expected_samples.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// testbench top for the ladder low-pass filter: stimulus, receiver stalls and verdict
module tb;
	import lp4_pkg::*;

	localparam int SW           = SAMPLE_WIDTH_DEF;
	localparam int FB           = FRAC_BITS_DEF;
	localparam int DW           = ((SW + 7) / 8) * 8;
	localparam int ONE          = 1 << FB;
	localparam int SMALL_AMP    = 1 << 18;
	localparam int N_PHASES     = 16;
	localparam int PHASE_ITEMS  = 100;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 400;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam logic [SW-1:0] S_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] S_MIN  = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SW-1:0] S_ZERO = '0;
	localparam logic [SW-1:0] S_ONE  = SW'(1);
	localparam logic [SW-1:0] S_NEG1 = '1;

	localparam logic [SW-1:0] DIR_RESET [8] = '{
		S_ZERO, S_MAX, S_MAX, S_MAX, S_MIN, S_MIN, S_ONE, S_NEG1
	};
	localparam logic [SW-1:0] DIR_HIGH [9] = '{
		S_MAX, S_MAX, S_MAX, S_ZERO, S_MIN, S_MIN, S_MIN, SW'(ONE), SW'(-ONE)
	};
	localparam logic [SW-1:0] DIR_WILD [6] = '{
		S_MAX, S_MIN, S_MAX, S_MIN, S_ZERO, S_ZERO
	};

	typedef enum int {STY_FULL, STY_SMALL, STY_SQUARE, STY_LIMITS} sig_style_t;
	typedef enum int {CK_TUNED, CK_EXTREME, CK_RAW, CK_GENTLE, CK_FLOOR} coef_kind_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [DW-1:0]         s_axis_tdata = '0;  // sample_in
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [DW-1:0]         m_axis_tdata;  // sample_out
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	int checked;
	int flips;

	int n_sent = 0;
	int n_writes = 0;
	int n_settings = 1;
	int idle_cycles = 0;
	int seg_left = 0;
	rx_mode_t seg_mode = RX_OPEN;

	ladder_lowpass_4pole u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	ladder_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.checked       (checked),
		.flips         (flips)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// receiver: segments of open, coin-flip, sparse and fully held tready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			seg_left <= 0;
			seg_mode <= RX_OPEN;
		end else begin
			if (seg_left == 0) begin
				seg_mode <= rx_mode_t'($urandom_range(0, 3));
				seg_left <= $urandom_range(1, 300);
			end else begin
				seg_left <= seg_left - 1;
			end
			case (seg_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) != 0);
				default:   m_axis_tready <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_sample(input logic [SW-1:0] v);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= DW'(v);
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic write_coefs(input logic [CFG_DATA_W-1:0] pole_v,
			input logic [CFG_DATA_W-1:0] half_v, input logic [CFG_DATA_W-1:0] res_v);
		logic [CFG_DATA_W-1:0] vals [3];
		cfg_reg_t regs [3];
		vals = '{pole_v, half_v, res_v};
		regs = '{REG_POLE, REG_HALF, REG_RES};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		n_writes += 3;
		n_settings++;
	endtask

	task automatic wait_idle(input int extra);
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic run_random(input int n_items, input sig_style_t style);
		int left;
		int burst;
		int gap;
		int sq_left;
		int amp;
		logic [SW-1:0] v;
		logic [SW-1:0] sq_level;
		left = n_items;
		sq_left = 0;
		sq_level = '0;
		while (left > 0) begin
			burst = $urandom_range(1, 8);
			if (burst > left) burst = left;
			repeat (burst) begin
				if ($urandom_range(0, 9) == 0) begin
					v = SW'($urandom);
				end else begin
					case (style)
						STY_FULL: v = SW'($urandom);
						STY_SMALL: v = SW'(int'($urandom_range(0, 2 * SMALL_AMP)) - SMALL_AMP);
						STY_SQUARE: begin
							// held levels of alternating sign
							if (sq_left == 0) begin
								sq_left = $urandom_range(1, 40);
								amp = $urandom_range(0, 2 ** (SW - 1) - 1);
								sq_level = sq_level[SW-1] ? SW'(amp) : SW'(-amp - 1);
							end
							v = sq_level;
							sq_left--;
						end
						default: begin
							case ($urandom_range(0, 4))
								0: v = S_MAX;
								1: v = S_MIN;
								2: v = S_ZERO;
								3: v = S_NEG1;
								default: v = S_ONE;
							endcase
						end
					endcase
				end
				push_sample(v);
				left--;
			end
			case ($urandom_range(0, 2))
				0: gap = 0;
				1: gap = $urandom_range(1, 16);
				default: gap = $urandom_range(17, 400);
			endcase
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		int pole_i;
		int half_i;
		int res_i;
		coef_kind_t kind;
		wait (arst_n);
		@(posedge clk);

		// reset coefficients
		foreach (DIR_RESET[i]) push_sample(DIR_RESET[i]);
		s_axis_tvalid <= 1'b0;
		wait_idle(4);

		// top of every range: full resonance, saturating signals
		write_coefs(CFG_DATA_W'(ONE), CFG_DATA_W'(ONE), CFG_DATA_W'(4 * ONE));
		foreach (DIR_HIGH[i]) push_sample(DIR_HIGH[i]);
		s_axis_tvalid <= 1'b0;
		wait_idle(4);

		// registers beyond their stated ranges
		write_coefs(CFG_DATA_W'(-2 * ONE), CFG_DATA_W'(2 * ONE - 1), CFG_DATA_W'(8 * ONE - 1));
		foreach (DIR_WILD[i]) push_sample(DIR_WILD[i]);
		s_axis_tvalid <= 1'b0;
		wait_idle(4);

		// unmapped register index must leave the coefficients alone
		cfg_valid <= 1'b1;
		cfg_index <= REG_SPARE;
		cfg_data <= CFG_DATA_W'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_writes++;

		for (int ph = 0; ph < N_PHASES; ph++) begin
			kind = coef_kind_t'((ph < 5) ? ph : $urandom_range(0, 4));
			case (kind)
				CK_TUNED, CK_GENTLE: begin
					pole_i = int'($urandom_range(0, 2 * ONE)) - ONE;
					half_i = (pole_i + ONE) / 2;
					res_i = (kind == CK_TUNED) ? $urandom_range(0, 4 * ONE) : $urandom_range(0, ONE);
				end
				CK_EXTREME: begin
					pole_i = $urandom_range(0, 1) ? ONE : -ONE;
					half_i = $urandom_range(0, 1) ? ONE : 0;
					res_i = $urandom_range(0, 1) ? 4 * ONE : 0;
				end
				CK_RAW: begin
					pole_i = $urandom;
					half_i = $urandom;
					res_i = $urandom;
				end
				default: begin
					pole_i = -ONE;
					half_i = 0;
					res_i = 0;
				end
			endcase
			write_coefs(CFG_DATA_W'(pole_i), CFG_DATA_W'(half_i), CFG_DATA_W'(res_i));
			run_random(PHASE_ITEMS, sig_style_t'($urandom_range(0, 3)));
			wait_idle(4);
		end

		wait_idle(DRAIN_CYCLES);
		$display("ran %0d samples through %0d coefficient settings, %0d register writes",
			n_sent, n_settings, n_writes);
		$display("%0d output samples compared, %0d clipper sign flips forced to zero",
			checked, flips);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/lp4_pkg.sv
src/lp4_mul.sv
src/lp4_core.sv
src/ladder_lowpass_4pole.sv
dv/ladder_checker.sv
dv/tb.sv
